// ===== hw/rtl/kab_pkg.sv =====
// kab_pkg: widths, table geometry, shared types and helpers for the k-th
// ancestor core (binary lifting). No dependencies.
package kab_pkg;

   // Field widths are fixed by the interface.
   localparam int NUM_BITS   = 11;   // node numbers, k, node_count
   localparam int OP_BITS    = 2;

   // Table geometry.
   localparam int MAX_NODES  = 1024;
   localparam int LOG_LEVELS = 11;
   localparam int NODE_BITS  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int LEVEL_BITS = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1;
   localparam int ADDR_BITS  = LEVEL_BITS + NODE_BITS;
   // Address is {level, node-1}; the top level only needs MAX_NODES rows.
   localparam int MEM_DEPTH  = (LOG_LEVELS - 1) * (1 << NODE_BITS) + MAX_NODES;

   localparam logic [LEVEL_BITS-1:0] LAST_LEVEL = LEVEL_BITS'(LOG_LEVELS - 1);
   localparam logic [NUM_BITS-1:0]   MAX_NODE_NUM = NUM_BITS'(MAX_NODES);

   // Operation codes.
   typedef enum logic [OP_BITS-1:0] {
      OP_LOAD  = 2'd0,
      OP_BUILD = 2'd1,
      OP_QUERY = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // Table port request: one write and one read port.
   typedef struct packed {
      logic                  wr_en;
      logic [ADDR_BITS-1:0]  wr_addr;
      logic [NUM_BITS-1:0]   wr_data;
      logic                  rd_en;
      logic [ADDR_BITS-1:0]  rd_addr;
   } mem_req_type;

   // Finished query result handed to the output stage.
   typedef struct packed {
      logic                  valid;
      logic [NUM_BITS-1:0]   ancestor;
      logic                  found;
   } res_type;

   function automatic logic [ADDR_BITS-1:0] entry_addr(
      input logic [LEVEL_BITS-1:0] level,
      input logic [NUM_BITS-1:0]   node
   );
      logic [NUM_BITS-1:0] idx;
      idx = node - NUM_BITS'(1);
      return {level, idx[NODE_BITS-1:0]};
   endfunction

   function automatic logic is_node(
      input logic [NUM_BITS-1:0] v,
      input logic [NUM_BITS-1:0] live
   );
      return (v != '0) && (v <= live);
   endfunction

endpackage

// ===== hw/rtl/kab_jump_mem.sv =====
// kab_jump_mem: jump table storage, one write and one registered read port.
// Depends on kab_pkg.
module kab_jump_mem
   import kab_pkg::*;
(
   input  logic                 clock,
   input  mem_req_type          mem_req,
   output logic [NUM_BITS-1:0]  rd_data
);

   logic [NUM_BITS-1:0] jump_mem [MEM_DEPTH];
   logic [NUM_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         jump_mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= jump_mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/kab_engine.sv =====
// kab_engine: sequencer for load, build and query words over the jump table.
// Depends on kab_pkg; drives kab_jump_mem through mem_req_type.
module kab_engine
   import kab_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [OP_BITS-1:0]   req_op,
   input  logic [NUM_BITS-1:0]  req_node,
   input  logic [NUM_BITS-1:0]  req_value,
   input  logic [NUM_BITS-1:0]  node_count,
   input  logic                 res_free,
   output res_type              res,
   output mem_req_type          mem_req,
   input  logic [NUM_BITS-1:0]  mem_rd_data
);

   typedef enum logic [7:0] {
      S_IDLE   = 8'b0000_0001,
      S_ROOT   = 8'b0000_0010,
      S_B_RD1  = 8'b0000_0100,
      S_B_RD2  = 8'b0000_1000,
      S_B_WR   = 8'b0001_0000,
      S_Q_SCAN = 8'b0010_0000,
      S_Q_WAIT = 8'b0100_0000,
      S_Q_DONE = 8'b1000_0000
   } state_type;

   state_type              state_ff, state_in;
   logic [LEVEL_BITS-1:0]  lv_ff, lv_in;       // build level / query level
   logic [NUM_BITS-1:0]    bnode_ff, bnode_in; // build node
   logic [NUM_BITS-1:0]    cur_ff, cur_in;     // query position
   logic [NUM_BITS-1:0]    k_ff, k_in;         // remaining k, shifted down

   logic [NUM_BITS-1:0]    live;
   logic [NUM_BITS-1:0]    rd_node;
   logic                   accept;

   assign live    = (node_count > MAX_NODE_NUM) ? MAX_NODE_NUM : node_count;
   assign rd_node = is_node(mem_rd_data, live) ? mem_rd_data : '0;
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      lv_in    = lv_ff;
      bnode_in = bnode_ff;
      cur_in   = cur_ff;
      k_in     = k_ff;
      mem_req  = '0;
      res      = '0;

      unique case (state_ff) inside
         S_IDLE: begin
            if (accept) begin
               unique case (op_type'(req_op))
                  OP_LOAD: begin
                     if (is_node(req_node, live)) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = entry_addr('0, req_node);
                        mem_req.wr_data = (req_node != NUM_BITS'(1)
                                           && is_node(req_value, live))
                                          ? req_value : '0;
                     end
                  end
                  OP_BUILD: begin
                     lv_in    = '0;
                     state_in = S_ROOT;
                  end
                  OP_QUERY: begin
                     cur_in = (is_node(req_node, live)
                               && ((req_value >> LOG_LEVELS) == '0))
                              ? req_node : '0;
                     k_in     = req_value;
                     lv_in    = '0;
                     state_in = S_Q_SCAN;
                  end
                  default: ;
               endcase
            end
         end

         // Root row: every level is none.
         S_ROOT: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = entry_addr(lv_ff, NUM_BITS'(1));
            mem_req.wr_data = '0;
            if (lv_ff == LAST_LEVEL) begin
               if ((LOG_LEVELS > 1) && (live >= NUM_BITS'(2))) begin
                  lv_in    = LEVEL_BITS'(1);
                  bnode_in = NUM_BITS'(2);
                  state_in = S_B_RD1;
               end else begin
                  lv_in    = '0;
                  state_in = S_IDLE;
               end
            end else begin
               lv_in = lv_ff + LEVEL_BITS'(1);
            end
         end

         S_B_RD1: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = entry_addr(lv_ff - LEVEL_BITS'(1), bnode_ff);
            state_in        = S_B_RD2;
         end

         // mid known: chase it, or store none when the chain ended; after the chase, store the result.
         S_B_RD2, S_B_WR: begin
            if ((state_ff == S_B_RD2) && (rd_node != '0)) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = entry_addr(lv_ff - LEVEL_BITS'(1), rd_node);
               state_in        = S_B_WR;
            end else begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = entry_addr(lv_ff, bnode_ff);
               mem_req.wr_data = (state_ff == S_B_WR) ? rd_node : '0;
               if (bnode_ff < live) begin
                  bnode_in = bnode_ff + NUM_BITS'(1);
                  state_in = S_B_RD1;
               end else if (lv_ff == LAST_LEVEL) begin
                  lv_in    = '0;
                  bnode_in = '0;
                  state_in = S_IDLE;
               end else begin
                  lv_in    = lv_ff + LEVEL_BITS'(1);
                  bnode_in = NUM_BITS'(2);
                  state_in = S_B_RD1;
               end
            end
         end

         S_Q_SCAN: begin
            if ((cur_ff == '0) || (k_ff == '0)) begin
               state_in = S_Q_DONE;
            end else if (k_ff[0]) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = entry_addr(lv_ff, cur_ff);
               state_in        = S_Q_WAIT;
            end else begin
               k_in  = k_ff >> 1;
               lv_in = lv_ff + LEVEL_BITS'(1);
            end
         end

         S_Q_WAIT: begin
            cur_in   = rd_node;
            k_in     = k_ff >> 1;
            lv_in    = (k_ff == NUM_BITS'(1)) ? lv_ff : lv_ff + LEVEL_BITS'(1);
            state_in = S_Q_SCAN;
         end

         S_Q_DONE: begin
            if (res_free) begin
               res.valid    = 1'b1;
               res.ancestor = cur_ff;
               res.found    = (cur_ff != '0);
               lv_in        = '0;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         lv_ff    <= '0;
         bnode_ff <= '0;
      end else begin
         state_ff <= state_in;
         lv_ff    <= lv_in;
         bnode_ff <= bnode_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      k_ff   <= k_in;
   end

`ifndef NO_ASSERTIONS
   // Single table port schedule: never read and write in one cycle.
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_req.wr_en && mem_req.rd_en))
      else $error("table read and write in the same cycle");

   // Wait states consume data from a read issued just before.
   a_wait_has_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_Q_WAIT || state_ff == S_B_RD2 || state_ff == S_B_WR)
      |-> $past(mem_req.rd_en))
      else $error("table data used without a preceding read");

   // A result leaves only with room downstream.
   a_res_room: assert property (@(posedge clock) disable iff (reset)
      res.valid |-> (res_free && state_ff == S_Q_DONE))
      else $error("result issued without output room");
`endif

endmodule

// ===== hw/rtl/kth_ancestor_binary_lifting_core.sv =====
// kth_ancestor_binary_lifting_core: top level; node_count register, output
// word register. Depends on kab_pkg, kab_engine and kab_jump_mem.
//
// Usage:
//  - req channel carries load, build and query words (op in req_tuser).
//    Load writes one parent into level 0; build fills levels 1 and up;
//    query returns the k-th ancestor of a node on the rsp channel.
//  - csr_wr_en/csr_wr_data write node_count; only while the core is idle.
//  - Load: writes the table in the accept cycle. Query: rsp_tvalid rises
//    after a walk over each bit position of k up to its highest set bit,
//    with a table read for each set bit (shorter when the chain ends early);
//    the next word is taken once the sequencer is back in idle. The walk is
//    set by the single-read-port table: each jump waits for the previous read.
//  - Build: writes the root row level by level, then for each of the
//    (live nodes - 1) x (LOG_LEVELS - 1) entries reads the level below, chases
//    the middle node if any and writes; the shared table port sets the pace.
//  - One word in flight at a time; req_tready is high whenever the sequencer
//    is idle, also while a result still waits in the rsp register.
//  - A stalled rsp holds its word; a finished query then waits in the core
//    until the register frees, and req_tready stays low meanwhile.
//  - Reset: node_count returns to 1, the sequencer to idle, rsp empties.
//    The table keeps its contents; entries are undefined until written.
module kth_ancestor_binary_lifting_core
   import kab_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,    // [10:0] node, [21:11] value, [23:22] zero
   input  logic [1:0]   req_tuser,    // [1:0] op
   // response channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [15:0]  rsp_tdata,    // [10:0] ancestor, [15:11] zero
   output logic [0:0]   rsp_tuser,    // [0] found
   // configuration
   input  logic         csr_wr_en,
   input  logic [10:0]  csr_wr_data   // node_count
);

   logic [NUM_BITS-1:0]  node_count_ff;
   logic                 rsp_valid_ff;
   logic [NUM_BITS-1:0]  rsp_anc_ff;
   logic                 rsp_found_ff;

   res_type              res;
   mem_req_type          mem_req;
   logic [NUM_BITS-1:0]  mem_rd_data;
   logic                 res_free;

   // Output register frees when empty or being taken this cycle.
   assign res_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NUM_BITS'(1);
      end else if (csr_wr_en) begin
         node_count_ff <= csr_wr_data;
      end
   end

   kab_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_op      (req_tuser),
      .req_node    (req_tdata[10:0]),
      .req_value   (req_tdata[21:11]),
      .node_count  (node_count_ff),
      .res_free    (res_free),
      .res         (res),
      .mem_req     (mem_req),
      .mem_rd_data (mem_rd_data)
   );

   kab_jump_mem u_jump_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res.valid) begin
         rsp_anc_ff   <= res.ancestor;
         rsp_found_ff <= res.found;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_anc_ff};
   assign rsp_tuser  = rsp_found_ff;

endmodule

// ===== test/kth_ancestor_binary_lifting_core_tb.sv =====
// Self-checking testbench for kth_ancestor_binary_lifting_core: binary-lifting predictor,
// stream driver and response checker. Needs kab_pkg and the core RTL only.
`timescale 1ns / 1ps

module kth_ancestor_binary_lifting_core_tb;
   import kab_pkg::*;

   // One request word waiting for the driver.
   typedef struct {
      op_type      op;
      logic [10:0] node;
      logic [10:0] value;   // parent for a load, k for a query
   } lift_cmd_type;

   // One expected response word.
   typedef struct {
      logic [10:0] ancestor;
      logic        found;
   } lift_answer_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // [10:0] node, [21:11] value, [23:22] zero
   logic [1:0]  req_tuser = '0;   // [1:0] op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b1;
   logic [15:0] rsp_tdata;        // [10:0] ancestor, [15:11] zero
   logic [0:0]  rsp_tuser;        // [0] found
   logic        csr_wr_en = 1'b0;
   logic [10:0] csr_wr_data = '0; // node_count

   // Predictor state: its own jump table and node_count copy.
   logic [10:0] lift_tab [1:MAX_NODES][LOG_LEVELS];
   logic [10:0] node_count_q = 11'd1;

   lift_cmd_type    req_backlog[$];
   lift_answer_type pending_answers[$];
   int unsigned  words_queued = 0;
   int unsigned  words_taken = 0;
   int unsigned  mismatches = 0;
   int unsigned  sender_idle_pct = 0;
   int unsigned  rsp_stall_pct = 0;
   bit           req_taken = 1'b0;

   kth_ancestor_binary_lifting_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #4 clock = ~clock;

   // --- predictor helpers ---------------------------------------------------

   // node_count saturates at the table size
   function automatic int unsigned live_nodes();
      return (node_count_q > MAX_NODES) ? MAX_NODES : node_count_q;
   endfunction

   function automatic bit valid_node(input int unsigned v);
      return (v >= 1) && (v <= live_nodes());
   endfunction

   // one table jump; anything that is not a live node reads as none (0)
   function automatic int unsigned hop(input int unsigned v, input int unsigned lv);
      int unsigned e;
      if (!valid_node(v))
         return 0;
      e = lift_tab[v][lv];
      return valid_node(e) ? e : 0;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatches < 100)
         $display("%0t: mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic push_cmd(input op_type op, input int unsigned node,
                           input int unsigned value);
      lift_cmd_type c;
      c.op    = op;
      c.node  = 11'(node);
      c.value = 11'(value);
      req_backlog.push_back(c);
      words_queued++;
   endtask

   // k picks: tiny, within the chain depth, single bit, any 11-bit value, or nd - 1
   function automatic int unsigned pick_k(input int unsigned nd);
      case ($urandom_range(0, 4))
         0: return $urandom_range(0, 3);
         1: return $urandom_range(0, nd - 1);
         2: return 1 << $urandom_range(0, LOG_LEVELS - 1);
         3: return $urandom_range(0, 2047);
         default: return nd - 1;
      endcase
   endfunction

   // --- driver: new word at the falling edge, hold until taken -------------

   always @(negedge clock) begin : drive_req
      lift_cmd_type c;
      if (!reset && !(req_tvalid && !req_taken)) begin
         if (req_backlog.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            c = req_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= c.op;
            req_tdata  <= {2'b00, c.value, c.node};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // random backpressure on the response side
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
   end

   // --- monitor: predict on request accept, check on response accept ------

   always @(posedge clock) begin : watch_ports
      lift_answer_type want;
      logic [10:0]  nd_w;
      logic [10:0]  val_w;
      int unsigned  cur;
      int unsigned  mid;
      int unsigned  n;
      int           lv;
      int           v;
      req_taken = !reset && req_tvalid && req_tready;
      if (req_taken) begin
         words_taken++;
         nd_w  = req_tdata[10:0];
         val_w = req_tdata[21:11];
         case (op_type'(req_tuser))
            OP_LOAD: begin
               // root always loads none; bad parent also stores none
               if (valid_node(nd_w))
                  lift_tab[nd_w][0] = (nd_w != 11'd1 && valid_node(val_w)) ? val_w : 11'd0;
            end
            OP_BUILD: begin
               n = live_nodes();
               for (lv = 0; lv < LOG_LEVELS; lv++)
                  lift_tab[1][lv] = '0;
               for (lv = 1; lv < LOG_LEVELS; lv++) begin
                  for (v = 2; v <= n; v++) begin
                     mid = hop(v, lv - 1);
                     lift_tab[v][lv] = (mid != 0) ? 11'(hop(mid, lv - 1)) : 11'd0;
                  end
               end
            end
            OP_QUERY: begin
               cur = valid_node(nd_w) ? nd_w : 0;
               if ((val_w >> LOG_LEVELS) != 0)
                  cur = 0;
               for (lv = 0; lv < LOG_LEVELS && cur != 0; lv++)
                  if (val_w[lv])
                     cur = hop(cur, lv);
               want.ancestor = 11'(cur);
               want.found    = (cur != 0);
               pending_answers.push_back(want);
            end
            default: ;   // OP_NONE: dropped, no response
         endcase
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_answers.size() == 0) begin
            report_mismatch($sformatf("unexpected rsp word tdata=%0h", rsp_tdata));
         end else begin
            want = pending_answers.pop_front();
            if (rsp_tdata !== {5'd0, want.ancestor})
               report_mismatch($sformatf("ancestor got %0d want %0d",
                                         rsp_tdata, want.ancestor));
            if (rsp_tuser[0] !== want.found)
               report_mismatch($sformatf("found got %b want %b",
                                         rsp_tuser[0], want.found));
         end
      end
   end

   // --- sequencing ----------------------------------------------------------

   // All queued words taken and answered; builds never end a phase, so the
   // core is idle once the closing query has come back.
   task automatic wait_quiet();
      do
         @(negedge clock);
      while (words_taken != words_queued || pending_answers.size() != 0);
      repeat (30) @(negedge clock);
   endtask

   task automatic set_node_count(input logic [10:0] cnt);
      wait_quiet();
      csr_wr_en    <= 1'b1;
      csr_wr_data  <= cnt;
      node_count_q = cnt;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Mostly well-formed bursts (loads of acyclic parents, build, queries),
   // the rest noise: random fields, bad nodes, cycles, unused op.
   task automatic run_phase(input logic [10:0] cnt, input int unsigned idle_pct,
                            input int unsigned stall_pct, input int unsigned n_words);
      int unsigned start;
      int unsigned lim;
      int unsigned nd;
      int unsigned r;
      int unsigned i;
      int unsigned reps;
      set_node_count(cnt);
      sender_idle_pct = idle_pct;
      rsp_stall_pct   = stall_pct;
      lim   = live_nodes();
      start = words_queued;
      while (words_queued - start < n_words) begin
         r = $urandom_range(0, 99);
         if (r < 75) begin
            reps = (lim >= 2) ? $urandom_range(0, 6) : 0;
            for (i = 0; i < reps; i++) begin
               nd = (i == 0 && r < 10) ? lim : $urandom_range(2, lim);
               push_cmd(OP_LOAD, nd, $urandom_range(1, nd - 1));
            end
            // full-size builds are long, so keep them rare
            if (lim <= 200 || $urandom_range(0, 3) == 0)
               push_cmd(OP_BUILD, 0, 0);
            reps = $urandom_range(2, 10);
            for (i = 0; i < reps; i++) begin
               nd = $urandom_range(1, lim);
               push_cmd(OP_QUERY, nd, pick_k(nd));
            end
         end else begin
            reps = $urandom_range(1, 4);
            for (i = 0; i < reps; i++) begin
               nd = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 2047)
                                                : $urandom_range(1, lim);
               r = $urandom_range(0, 9);
               if (r < 4)
                  push_cmd(OP_LOAD, nd, $urandom_range(0, 2047));
               else if (r == 8)
                  push_cmd(OP_NONE, nd, $urandom_range(0, 2047));
               else if (r == 9 && lim <= 200)
                  push_cmd(OP_BUILD, nd, $urandom_range(0, 2047));
               else
                  push_cmd(OP_QUERY, nd, $urandom_range(0, 2047));
            end
         end
      end
      // closing query: its answer marks the end of the phase
      push_cmd(OP_QUERY, lim, pick_k(lim));
   endtask

   initial begin : main_seq
      int unsigned v;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Fill the whole table once so no later access hits an unwritten entry.
      // Parents mostly v-1 so the tree is deep.
      set_node_count(11'(MAX_NODES));
      for (v = 1; v <= MAX_NODES; v++)
         push_cmd(OP_LOAD, v, (v == 1) ? 0 :
                  (($urandom_range(0, 99) < 85) ? v - 1 : $urandom_range(1, v - 1)));
      push_cmd(OP_BUILD, 0, 0);

      // directed corners
      push_cmd(OP_QUERY, 1, 0);          // k of zero on the root
      push_cmd(OP_QUERY, 1, 1);          // above the root
      push_cmd(OP_QUERY, 1024, 0);
      push_cmd(OP_QUERY, 1024, 1);
      push_cmd(OP_QUERY, 1024, 1023);
      push_cmd(OP_QUERY, 1024, 1024);    // top level only
      push_cmd(OP_QUERY, 1024, 2047);    // runs out of ancestors
      push_cmd(OP_QUERY, 0, 0);          // bad node
      push_cmd(OP_QUERY, 1025, 0);
      push_cmd(OP_QUERY, 2047, 5);
      push_cmd(OP_NONE, 5, 1);           // unused op, dropped
      push_cmd(OP_LOAD, 1, 7);           // root stores none
      push_cmd(OP_LOAD, 0, 3);           // bad nodes, ignored
      push_cmd(OP_LOAD, 1025, 3);
      push_cmd(OP_LOAD, 2047, 2047);
      push_cmd(OP_LOAD, 5, 0);           // parent zero
      push_cmd(OP_LOAD, 6, 2047);        // parent out of range
      push_cmd(OP_LOAD, 7, 7);           // self loop
      push_cmd(OP_LOAD, 8, 1024);        // parent below, makes a cycle
      push_cmd(OP_BUILD, 0, 0);
      push_cmd(OP_QUERY, 7, 3);
      push_cmd(OP_QUERY, 6, 1);
      push_cmd(OP_QUERY, 9, 2);
      push_cmd(OP_QUERY, 1024, 10);
      push_cmd(OP_QUERY, 512, 11'h555);

      run_phase(11'd1024, 0, 0, 30);
      run_phase(11'd16, 83, 0, 30);
      run_phase(11'd100, 0, 83, 30);
      run_phase(11'd1, 23, 23, 15);      // root only
      run_phase(11'd2047, 0, 0, 20);     // saturates at table size
      run_phase(11'd5, 23, 23, 30);
      run_phase(11'd300, 83, 0, 20);
      run_phase(11'd64, 0, 83, 25);

      wait_quiet();
      if (mismatches == 0 && pending_answers.size() == 0) begin
         $display("kth_ancestor_binary_lifting_core test passed");
      end else begin
         $display("kth_ancestor_binary_lifting_core test failed");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin : watchdog
      #30_000_000;
      $display("kth_ancestor_binary_lifting_core test failed");
      $finish;
   end

endmodule
